### hdl/obb_pkg.sv
`default_nettype none
package obb_pkg;

  // Sine and cosine are Q1.14 values in [-16384, 16384].
  localparam int TRIG_BITS = 16;
  localparam int Q14_ONE = 16384;

  // Rotation core: 16 micro-rotations on a 2^30 scale.
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W = 34;
  localparam int CORDIC_RND_W = CORDIC_W - 16;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Pipeline depths, in stages.
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int BOX_LAT = CORDIC_LAT + 2;
  localparam int LANE_LAT = 5;
  localparam int PIPE_LAT = BOX_LAT + LANE_LAT + 2;

  localparam int NUM_AXES = 4;

  typedef logic signed [TRIG_BITS-1:0] trig_t;

  typedef struct packed {
    logic w_zero;
    logic h_zero;
  } box_flags_t;

  function automatic trig_t clamp_q14(input logic signed [CORDIC_RND_W-1:0] v);
    trig_t r;
    if (v > CORDIC_RND_W'(Q14_ONE)) begin
      r = TRIG_BITS'(Q14_ONE);
    end else if (v < -CORDIC_RND_W'(Q14_ONE)) begin
      r = -TRIG_BITS'(Q14_ONE);
    end else begin
      r = v[TRIG_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/obb_in_if.sv
`default_nettype none
interface obb_in_if #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_pos_x;
  logic signed [COORD_BITS-1:0] first_pos_y;
  logic [COORD_BITS-1:0]        first_width;
  logic [COORD_BITS-1:0]        first_height;
  logic [ANGLE_BITS-1:0]        first_angle;
  logic signed [COORD_BITS-1:0] second_pos_x;
  logic signed [COORD_BITS-1:0] second_pos_y;
  logic [COORD_BITS-1:0]        second_width;
  logic [COORD_BITS-1:0]        second_height;
  logic [ANGLE_BITS-1:0]        second_angle;

  modport source (
    output valid, first_pos_x, first_pos_y, first_width, first_height, first_angle,
           second_pos_x, second_pos_y, second_width, second_height, second_angle,
    input  ready
  );
  modport sink (
    input  valid, first_pos_x, first_pos_y, first_width, first_height, first_angle,
           second_pos_x, second_pos_y, second_width, second_height, second_angle,
    output ready
  );
endinterface
`default_nettype wire

### hdl/obb_out_if.sv
`default_nettype none
interface obb_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface
`default_nettype wire

### hdl/obb_cordic.sv
`default_nettype none
module obb_cordic import obb_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [ANGLE_BITS-1:0] angle,
  output trig_t                      cs,
  output trig_t                      sn
);

  logic [31:0] phase;
  logic        flip_in;
  logic signed [CORDIC_W-1:0] xs [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] ys [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] zs [0:CORDIC_STEPS];
  logic flip_d [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] x_rnd;
  logic signed [CORDIC_W-1:0] y_rnd;
  trig_t c_clamp;
  trig_t s_clamp;

  assign phase = {angle, {(32 - ANGLE_BITS){1'b0}}};
  // Second and third quadrants are turned by half a turn and negated at the end.
  assign flip_in = phase[31] ^ phase[30];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= CORDIC_GAIN;
      ys[0] <= '0;
      zs[0] <= CORDIC_W'(signed'({phase[31] ^ flip_in, phase[30:0]}));
      flip_d[0] <= flip_in;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic signed [CORDIC_W-1:0] da;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign da = signed'({2'b00, ATAN_TURN[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][CORDIC_W-1]) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - da;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + da;
        end
        flip_d[i+1] <= flip_d[i];
      end
    end
  end

  assign x_rnd = xs[CORDIC_STEPS] + CORDIC_W'(32768);
  assign y_rnd = ys[CORDIC_STEPS] + CORDIC_W'(32768);
  assign c_clamp = clamp_q14(x_rnd[CORDIC_W-1:16]);
  assign s_clamp = clamp_q14(y_rnd[CORDIC_W-1:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      cs <= flip_d[CORDIC_STEPS] ? -c_clamp : c_clamp;
      sn <= flip_d[CORDIC_STEPS] ? -s_clamp : s_clamp;
    end
  end

endmodule
`default_nettype wire

### hdl/obb_box.sv
`default_nettype none
module obb_box import obb_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16,
  localparam int CW = COORD_BITS + 3,
  localparam int PW = COORD_BITS + 17
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic signed [COORD_BITS-1:0] px,
  input  wire logic signed [COORD_BITS-1:0] py,
  input  wire logic [COORD_BITS-1:0]        w,
  input  wire logic [COORD_BITS-1:0]        h,
  input  wire logic [ANGLE_BITS-1:0]        angle,
  output logic signed [CW-1:0]              cx [4],
  output logic signed [CW-1:0]              cy [4],
  output trig_t                             cs,
  output trig_t                             sn,
  output box_flags_t                        flags
);

  logic signed [COORD_BITS-1:0] px_d [0:CORDIC_LAT-1];
  logic signed [COORD_BITS-1:0] py_d [0:CORDIC_LAT-1];
  logic [COORD_BITS-1:0] w_d [0:CORDIC_LAT-1];
  logic [COORD_BITS-1:0] h_d [0:CORDIC_LAT-1];
  trig_t cs_c;
  trig_t sn_c;
  logic signed [PW-1:0] wc;
  logic signed [PW-1:0] ws;
  logic signed [PW-1:0] hc;
  logic signed [PW-1:0] hs;
  logic signed [CW-1:0] cen_x;
  logic signed [CW-1:0] cen_y;
  trig_t cs_a;
  trig_t sn_a;
  box_flags_t flags_a;

  obb_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk  (clk),
    .en   (en),
    .angle(angle),
    .cs   (cs_c),
    .sn   (sn_c)
  );

  // Geometry waits beside the rotation core.
  always_ff @(posedge clk) begin
    if (en) begin
      px_d[0] <= px;
      py_d[0] <= py;
      w_d[0]  <= w;
      h_d[0]  <= h;
      for (int k = 1; k < CORDIC_LAT; k++) begin
        px_d[k] <= px_d[k-1];
        py_d[k] <= py_d[k-1];
        w_d[k]  <= w_d[k-1];
        h_d[k]  <= h_d[k-1];
      end
    end
  end

  // Half-size products and the doubled center, which is exact in Q.5.
  always_ff @(posedge clk) begin
    if (en) begin
      wc <= $signed({1'b0, w_d[CORDIC_LAT-1]}) * cs_c;
      ws <= $signed({1'b0, w_d[CORDIC_LAT-1]}) * sn_c;
      hc <= $signed({1'b0, h_d[CORDIC_LAT-1]}) * cs_c;
      hs <= $signed({1'b0, h_d[CORDIC_LAT-1]}) * sn_c;
      cen_x <= (CW'(px_d[CORDIC_LAT-1]) <<< 1) + CW'($signed({1'b0, w_d[CORDIC_LAT-1]}));
      cen_y <= (CW'(py_d[CORDIC_LAT-1]) <<< 1) + CW'($signed({1'b0, h_d[CORDIC_LAT-1]}));
      cs_a <= cs_c;
      sn_a <= sn_c;
      flags_a.w_zero <= (w_d[CORDIC_LAT-1] == '0);
      flags_a.h_zero <= (h_d[CORDIC_LAT-1] == '0);
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_corner
    localparam bit XPOS = (k % 2) == 1;
    localparam bit YPOS = k >= 2;
    logic signed [PW:0] ex;
    logic signed [PW:0] ey;
    logic signed [PW:0] rx;
    logic signed [PW:0] ry;
    assign ex = (XPOS ? (PW+1)'(wc) : -(PW+1)'(wc)) - (YPOS ? (PW+1)'(hs) : -(PW+1)'(hs));
    assign ey = (XPOS ? (PW+1)'(ws) : -(PW+1)'(ws)) + (YPOS ? (PW+1)'(hc) : -(PW+1)'(hc));
    assign rx = (ex + (PW+1)'(8192)) >>> 14;
    assign ry = (ey + (PW+1)'(8192)) >>> 14;
    always_ff @(posedge clk) begin
      if (en) begin
        cx[k] <= cen_x + CW'(rx);
        cy[k] <= cen_y + CW'(ry);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs    <= cs_a;
      sn    <= sn_a;
      flags <= flags_a;
    end
  end

endmodule
`default_nettype wire

### hdl/obb_lane.sv
`default_nettype none
module obb_lane import obb_pkg::*; #(
  parameter int CW = 19,
  localparam int MW = CW + TRIG_BITS,
  localparam int DW = MW + 1
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic signed [CW-1:0] cx [8],
  input  wire logic signed [CW-1:0] cy [8],
  input  wire trig_t             dx,
  input  wire trig_t             dy,
  input  wire logic              skip,
  output logic                   ok
);

  logic signed [MW-1:0] pa [8];
  logic signed [MW-1:0] pb [8];
  logic signed [DW-1:0] d [8];
  logic signed [DW-1:0] mn_p [4];
  logic signed [DW-1:0] mx_p [4];
  logic signed [DW-1:0] mn1;
  logic signed [DW-1:0] mx1;
  logic signed [DW-1:0] mn2;
  logic signed [DW-1:0] mx2;
  logic [3:0] skip_d;

  // Corners 0..3 belong to the first box, 4..7 to the second.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 8; k++) begin
        pa[k] <= cx[k] * dx;
        pb[k] <= cy[k] * dy;
      end
      for (int k = 0; k < 8; k++) begin
        d[k] <= DW'(pa[k]) + DW'(pb[k]);
      end
      for (int j = 0; j < 4; j++) begin
        mn_p[j] <= (d[2*j] < d[2*j+1]) ? d[2*j] : d[2*j+1];
        mx_p[j] <= (d[2*j] > d[2*j+1]) ? d[2*j] : d[2*j+1];
      end
      mn1 <= (mn_p[0] < mn_p[1]) ? mn_p[0] : mn_p[1];
      mx1 <= (mx_p[0] > mx_p[1]) ? mx_p[0] : mx_p[1];
      mn2 <= (mn_p[2] < mn_p[3]) ? mn_p[2] : mn_p[3];
      mx2 <= (mx_p[2] > mx_p[3]) ? mx_p[2] : mx_p[3];
      skip_d <= {skip_d[2:0], skip};
      // Touching intervals count as overlapping.
      ok <= skip_d[3] || ((mn2 <= mx1) && (mx2 >= mn1));
    end
  end

endmodule
`default_nettype wire

### hdl/oriented_box_overlap_test.sv
// Oriented box overlap test: separating axis test for two rotated rectangles.
//
// Input channel box_in carries one box pair per beat: for each box its corner,
// width and height in Q12.4 and its rotation as a fraction of a full turn.
// Output channel result carries one beat per input beat with a single bit,
// overlap, which is high unless an edge direction of either box separates them.
//
// The block is a fixed pipeline of 27 stages, and a new beat is taken every
// cycle while the receiver does not stall. The depth is set by the 16-step
// rotation core (18 stages), corner rotation (2), the axis lanes (5) and input
// and output registers. Four lanes, one per axis, project all eight corners in
// parallel.
//
// The pipeline moves as a whole. When a result waits at the output and the
// receiver holds ready low, every stage holds and box_in.ready drops in the same
// cycle; it returns as soon as the waiting beat is taken. Synchronous reset
// empties the pipeline; no result is pending afterwards.
`default_nettype none
module oriented_box_overlap_test import obb_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  obb_in_if.sink   box_in,
  obb_out_if.source result
);

  localparam int CW = COORD_BITS + 3;

  // Valid bit of each pipeline stage; data registers move with it.
  logic [PIPE_LAT-1:0] stage_valid;
  logic adv;

  logic signed [COORD_BITS-1:0] a_px, a_py, b_px, b_py;
  logic [COORD_BITS-1:0] a_w, a_h, b_w, b_h;
  logic [ANGLE_BITS-1:0] a_ang, b_ang;

  logic signed [CW-1:0] a_cx [4];
  logic signed [CW-1:0] a_cy [4];
  logic signed [CW-1:0] b_cx [4];
  logic signed [CW-1:0] b_cy [4];
  trig_t a_cs, a_sn, b_cs, b_sn;
  box_flags_t a_flags, b_flags;

  logic signed [CW-1:0] all_cx [8];
  logic signed [CW-1:0] all_cy [8];
  trig_t ax_x [NUM_AXES];
  trig_t ax_y [NUM_AXES];
  logic [NUM_AXES-1:0] ax_skip;
  logic [NUM_AXES-1:0] lane_ok;
  logic overlap;

  // The whole pipeline steps unless a finished result is held by the receiver.
  assign adv = !stage_valid[PIPE_LAT-1] || result.ready;
  assign box_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (adv) begin
      stage_valid <= {stage_valid[PIPE_LAT-2:0], box_in.valid};
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_px  <= box_in.first_pos_x;
      a_py  <= box_in.first_pos_y;
      a_w   <= box_in.first_width;
      a_h   <= box_in.first_height;
      a_ang <= box_in.first_angle;
      b_px  <= box_in.second_pos_x;
      b_py  <= box_in.second_pos_y;
      b_w   <= box_in.second_width;
      b_h   <= box_in.second_height;
      b_ang <= box_in.second_angle;
    end
  end

  obb_box #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_box_a (
    .clk(clk), .en(adv), .px(a_px), .py(a_py), .w(a_w), .h(a_h), .angle(a_ang),
    .cx(a_cx), .cy(a_cy), .cs(a_cs), .sn(a_sn), .flags(a_flags)
  );

  obb_box #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_box_b (
    .clk(clk), .en(adv), .px(b_px), .py(b_py), .w(b_w), .h(b_h), .angle(b_ang),
    .cx(b_cx), .cy(b_cy), .cs(b_cs), .sn(b_sn), .flags(b_flags)
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      all_cx[k]   = a_cx[k];
      all_cy[k]   = a_cy[k];
      all_cx[k+4] = b_cx[k];
      all_cy[k+4] = b_cy[k];
    end
  end

  // Axes: first box width and height edges, then second box height and width
  // edges. An edge of zero length cannot separate, so its lane is skipped.
  assign ax_x[0] = a_cs;
  assign ax_y[0] = a_sn;
  assign ax_skip[0] = a_flags.w_zero;
  assign ax_x[1] = a_sn;
  assign ax_y[1] = -a_cs;
  assign ax_skip[1] = a_flags.h_zero;
  assign ax_x[2] = b_sn;
  assign ax_y[2] = -b_cs;
  assign ax_skip[2] = b_flags.h_zero;
  assign ax_x[3] = b_cs;
  assign ax_y[3] = b_sn;
  assign ax_skip[3] = b_flags.w_zero;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    obb_lane #(.CW(CW)) u_lane (
      .clk(clk), .en(adv), .cx(all_cx), .cy(all_cy),
      .dx(ax_x[a]), .dy(ax_y[a]), .skip(ax_skip[a]), .ok(lane_ok[a])
    );
  end

  // Merge: the boxes overlap only if every lane found overlap.
  always_ff @(posedge clk) begin
    if (adv) begin
      overlap <= &lane_ok;
    end
  end

  assign result.valid   = stage_valid[PIPE_LAT-1];
  assign result.overlap = overlap;

endmodule
`default_nettype wire

### hdl/obb_checker.sv
`default_nettype none
module obb_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic overlap
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(overlap))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind oriented_box_overlap_test obb_checker u_obb_checker (
  .clk      (clk),
  .rst      (rst),
  .in_ready (box_in.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .overlap  (result.overlap)
);
`default_nettype wire

### verif/tb.sv
`default_nettype none
module tb;
  import obb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = PIPE_LAT + 20;
  localparam int STUCK_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int HOLD_OFF_CYCLES = 200;

  // One box pair, exactly as it travels on the input channel.
  typedef struct {
    logic signed [15:0] px1, py1;
    logic [15:0]        w1, h1, a1;
    logic signed [15:0] px2, py2;
    logic [15:0]        w2, h2, a2;
  } box_pair_t;

  // Keeps the expected overlap bits in order and computes each one from the
  // accepted input beat with an independent fixed-point model of the block.
  class overlap_scoreboard;
    bit overlap_q[$];
    int errors;

    // Rotation core: sine and cosine in Q1.14 from a 16-bit turn fraction.
    function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                    output longint s);
      logic [31:0] phase;
      logic [31:0] p;
      bit flip;
      longint x, y, z, dx, dy;
      phase = {ang, 16'h0000};
      flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
      p = flip ? phase - 32'h80000000 : phase;
      z = $signed(p);
      x = CORDIC_GAIN;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
        end
      end
      c = (x + 32768) >>> 16;
      s = (y + 32768) >>> 16;
      if (c > 16384) c = 16384;
      if (c < -16384) c = -16384;
      if (s > 16384) s = 16384;
      if (s < -16384) s = -16384;
      if (flip) begin
        c = -c;
        s = -s;
      end
    endfunction

    // Corners are kept in doubled units so that the centre is exact.
    function automatic void corners(input logic signed [15:0] px, py,
                                    input logic [15:0] w, h, input longint c, s,
                                    output longint cx[4], output longint cy[4]);
      longint ox, oy, rx, ry;
      for (int k = 0; k < 4; k++) begin
        ox = (k % 2 == 0) ? -longint'(w) : longint'(w);
        oy = (k < 2) ? -longint'(h) : longint'(h);
        rx = ox * c - oy * s;
        ry = ox * s + oy * c;
        cx[k] = 2 * longint'(px) + longint'(w) + ((rx + 8192) >>> 14);
        cy[k] = 2 * longint'(py) + longint'(h) + ((ry + 8192) >>> 14);
      end
    endfunction

    function automatic bit axis_meets(input longint ax[4], ay[4], bx[4], by[4],
                                      input longint dx, dy);
      longint mn1, mx1, mn2, mx2, d;
      for (int k = 0; k < 4; k++) begin
        d = ax[k] * dx + ay[k] * dy;
        if (k == 0 || d < mn1) mn1 = d;
        if (k == 0 || d > mx1) mx1 = d;
        d = bx[k] * dx + by[k] * dy;
        if (k == 0 || d < mn2) mn2 = d;
        if (k == 0 || d > mx2) mx2 = d;
      end
      return (mn2 <= mx1) && (mx2 >= mn1);
    endfunction

    function automatic bit boxes_overlap(input box_pair_t bp);
      longint c1, s1, c2, s2;
      longint ax[4], ay[4], bx[4], by[4];
      bit hit;
      sin_cos(bp.a1, c1, s1);
      sin_cos(bp.a2, c2, s2);
      corners(bp.px1, bp.py1, bp.w1, bp.h1, c1, s1, ax, ay);
      corners(bp.px2, bp.py2, bp.w2, bp.h2, c2, s2, bx, by);
      hit = 1'b1;
      // A zero-length edge gives no axis, so it cannot separate the boxes.
      if (bp.w1 != 0 && !axis_meets(ax, ay, bx, by, c1, s1)) hit = 1'b0;
      if (bp.h1 != 0 && !axis_meets(ax, ay, bx, by, s1, -c1)) hit = 1'b0;
      if (bp.h2 != 0 && !axis_meets(ax, ay, bx, by, s2, -c2)) hit = 1'b0;
      if (bp.w2 != 0 && !axis_meets(ax, ay, bx, by, c2, s2)) hit = 1'b0;
      return hit;
    endfunction

    function void note_pair(input box_pair_t bp);
      overlap_q.insert(overlap_q.size(), boxes_overlap(bp));
    endfunction

    function void check_result(input logic got);
      bit want;
      if (overlap_q.size() == 0) begin
        $display("%0t: unexpected result beat, overlap=%b", $time, got);
        errors++;
      end else begin
        want = overlap_q.pop_front();
        if (got !== want) begin
          $display("%0t: overlap mismatch, expected %b, actual %b", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  obb_in_if #(.COORD_BITS(16), .ANGLE_BITS(16)) box_in_ch ();
  obb_out_if result_ch ();

  oriented_box_overlap_test #(.COORD_BITS(16), .ANGLE_BITS(16)) dut (
    .clk(clk),
    .rst(rst),
    .box_in(box_in_ch),
    .result(result_ch)
  );

  overlap_scoreboard scoreboard = new();

  // Idling knobs, changed per phase by the main sequence.
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_request;
  int stuck_cycles;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  initial begin
    rst = 1'b1;
    box_in_ch.valid <= 1'b0;
    box_in_ch.first_pos_x <= '0;
    box_in_ch.first_pos_y <= '0;
    box_in_ch.first_width <= '0;
    box_in_ch.first_height <= '0;
    box_in_ch.first_angle <= '0;
    box_in_ch.second_pos_x <= '0;
    box_in_ch.second_pos_y <= '0;
    box_in_ch.second_width <= '0;
    box_in_ch.second_height <= '0;
    box_in_ch.second_angle <= '0;
    result_ch.ready <= 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off on request so that the
  // pipeline fills up and pushes back on the input channel.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_request > 0) begin
        hold_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Monitor: both channels are sampled at the edge, before any driver update.
  // It also runs the watchdog, which counts cycles in which no beat moves.
  always @(posedge clk) begin
    if (!rst) begin
      if (box_in_ch.valid && box_in_ch.ready) begin
        scoreboard.note_pair('{box_in_ch.first_pos_x, box_in_ch.first_pos_y,
                               box_in_ch.first_width, box_in_ch.first_height,
                               box_in_ch.first_angle, box_in_ch.second_pos_x,
                               box_in_ch.second_pos_y, box_in_ch.second_width,
                               box_in_ch.second_height, box_in_ch.second_angle});
      end
      if (result_ch.valid && result_ch.ready) begin
        scoreboard.check_result(result_ch.overlap);
      end
      if ((box_in_ch.valid && box_in_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offers one beat after a random idle gap and returns once it is taken.
  // Valid is never dropped between back-to-back beats.
  task automatic send_pair(input box_pair_t bp);
    while ($urandom_range(99) < sender_idle_pct) begin
      box_in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    box_in_ch.valid <= 1'b1;
    box_in_ch.first_pos_x <= bp.px1;
    box_in_ch.first_pos_y <= bp.py1;
    box_in_ch.first_width <= bp.w1;
    box_in_ch.first_height <= bp.h1;
    box_in_ch.first_angle <= bp.a1;
    box_in_ch.second_pos_x <= bp.px2;
    box_in_ch.second_pos_y <= bp.py2;
    box_in_ch.second_width <= bp.w2;
    box_in_ch.second_height <= bp.h2;
    box_in_ch.second_angle <= bp.a2;
    do @(posedge clk); while (!box_in_ch.ready);
  endtask

  function automatic box_pair_t make_pair();
    box_pair_t bp;
    int mode;
    mode = $urandom_range(99);
    bp.a1 = 16'($urandom);
    bp.a2 = 16'($urandom);
    if (mode < 75) begin
      // Boxes close together, so both outcomes come up often.
      bp.px1 = 16'($signed($urandom_range(8000)) - 4000);
      bp.py1 = 16'($signed($urandom_range(8000)) - 4000);
      bp.w1 = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(800));
      bp.h1 = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(800));
      bp.w2 = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(800));
      bp.h2 = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(800));
      bp.px2 = 16'(bp.px1 + $signed($urandom_range(1600)) - 800);
      bp.py2 = 16'(bp.py1 + $signed($urandom_range(1600)) - 800);
      if ($urandom_range(3) == 0) begin
        bp.a1 = {2'($urandom_range(3)), 14'h0000};
        bp.a2 = {2'($urandom_range(3)), 14'h0000};
      end
    end else begin
      // Any bit pattern at all, huge sizes included.
      bp.px1 = 16'($urandom);
      bp.py1 = 16'($urandom);
      bp.w1 = 16'($urandom);
      bp.h1 = 16'($urandom);
      bp.px2 = 16'($urandom);
      bp.py2 = 16'($urandom);
      bp.w2 = 16'($urandom);
      bp.h2 = 16'($urandom);
    end
    return bp;
  endfunction

  initial begin
    box_pair_t directed[$];
    int idle_plan[4];
    int stall_plan[4];
    int drain;

    idle_plan = '{0, 77, 0, 35};
    stall_plan = '{0, 0, 77, 35};
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_request = 0;
    stuck_cycles = 0;

    // Directed beats: field extremes, the quarter-turn angles and the last
    // angle code, both zero-size cases, touching edges and far-apart boxes.
    directed.insert(directed.size(), '{0, 0, 16, 16, 0, 16, 0, 16, 16, 0});
    directed.insert(directed.size(), '{0, 0, 16, 16, 0, 17, 0, 16, 16, 0});
    directed.insert(directed.size(), '{0, 0, 16, 16, 0, 0, 16, 16, 16, 0});
    directed.insert(directed.size(), '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.insert(directed.size(), '{0, 0, 0, 50, 0, 100, 0, 0, 50, 0});
    directed.insert(directed.size(), '{0, 0, 50, 0, 0, 0, 100, 50, 0, 0});
    directed.insert(directed.size(), '{0, 0, 100, 40, 16384, 30, 10, 20, 20, 32768});
    directed.insert(directed.size(), '{0, 0, 100, 40, 49152, 0, 0, 100, 40, 65535});
    directed.insert(directed.size(), '{0, 0, 100, 100, 8192, 150, 150, 100, 100, 8192});
    directed.insert(directed.size(), '{0, 0, 100, 100, 8192, 210, 0, 100, 100, 0});
    directed.insert(directed.size(), '{-32768, -32768, 16, 16, 0, 32767, 32767, 16, 16, 0});
    directed.insert(directed.size(), '{32767, 32767, 65535, 65535, 65535, -32768, -32768,
                                       65535, 65535, 1});
    directed.insert(directed.size(), '{-32768, 32767, 65535, 0, 24576, 32767, -32768, 0,
                                       65535, 40960});
    directed.insert(directed.size(), '{-32768, -32768, 65535, 65535, 0, 32767, 32767,
                                       65535, 65535, 0});
    directed.insert(directed.size(), '{100, 100, 1, 1, 12345, 100, 100, 1, 1, 54321});
    directed.insert(directed.size(), '{-1, -1, 65535, 65535, 32767, -1, -1, 1, 1, 32769});
    directed.insert(directed.size(), '{1000, -1000, 300, 20, 60000, 1200, -900, 20, 300,
                                       5000});
    directed.insert(directed.size(), '{0, 0, 32768, 32768, 16383, 16384, 16384, 32767,
                                       32767, 16385});

    rst = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_pair(directed[i]);

    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_plan[ph];
      receiver_stall_pct = stall_plan[ph];
      // In the first phase the sender runs flat out while the receiver holds
      // off for a long stretch, which must stall the input channel.
      if (ph == 0) hold_off_request = HOLD_OFF_CYCLES;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_pair(make_pair());
    end
    box_in_ch.valid <= 1'b0;
    receiver_stall_pct = 20;

    // Wait for every expected beat; the watchdog catches a hang here.
    while (scoreboard.overlap_q.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end

    if (scoreboard.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hdl/obb_pkg.sv
hdl/obb_in_if.sv
hdl/obb_out_if.sv
hdl/obb_cordic.sv
hdl/obb_box.sv
hdl/obb_lane.sv
hdl/oriented_box_overlap_test.sv
hdl/obb_checker.sv
verif/tb.sv
